// ----- rtl/core/vbfr_pkg.sv -----
package vbfr_pkg;

	localparam int BYTE_W      = 8;
	localparam int SLOT_W      = 6;
	localparam int MAX_RESULTS = 4;
	localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);
	localparam int IDX_W       = $clog2(MAX_RESULTS);
	localparam int POS_W       = 4;

	localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hAA;
	localparam logic [BYTE_W-1:0] HDR_CMD    = 8'h10;

	localparam logic [POS_W-1:0] HDR_LEN     = 4'd8;
	localparam logic [POS_W-1:0] HDR_DST_HI  = 4'd2;
	localparam logic [POS_W-1:0] HDR_SRC_LO  = 4'd3;
	localparam logic [POS_W-1:0] HDR_FRAMES  = 4'd7;
	localparam logic [POS_W-1:0] FRM_DATA_N  = 4'd4;
	localparam logic [POS_W-1:0] FRM_SEPTET  = 4'd4;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_DATA   = 2'd1,
		KIND_ERROR  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] value;
		logic [SLOT_W-1:0] slot;
	} result_t;

	typedef struct packed {
		logic [COUNT_W-1:0]          count;
		result_t [MAX_RESULTS-1:0]   res;
	} result_set_t;

endpackage

// ----- rtl/core/vbfr_if.sv -----
interface vbfr_byte_if;
	logic                        valid;
	logic                        ready;
	logic [vbfr_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface vbfr_result_if;
	logic                        valid;
	logic                        ready;
	vbfr_pkg::kind_t             kind;
	logic [vbfr_pkg::BYTE_W-1:0] value;
	logic [vbfr_pkg::SLOT_W-1:0] slot;
	logic                        last;

	modport source (output valid, output kind, output value, output slot, output last,
		input ready);
	modport sink   (input valid, input kind, input value, input slot, input last,
		output ready);
endinterface

interface vbfr_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [vbfr_pkg::BYTE_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/vbfr_parser.sv -----
module vbfr_parser #(
	parameter int OUT_CAPACITY = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [vbfr_pkg::BYTE_W-1:0] rx_byte,
	input  logic [vbfr_pkg::BYTE_W-1:0] sync_byte,
	output vbfr_pkg::result_set_t       set
);
	import vbfr_pkg::*;

	localparam int CNT_RAW = $clog2(OUT_CAPACITY + MAX_RESULTS);
	localparam int CNT_W   = (CNT_RAW > SLOT_W) ? CNT_RAW : SLOT_W;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HEAD,
		PH_DATA
	} phase_t;

	phase_t             phase_q,  phase_d;
	logic [POS_W-1:0]   pos_q,    pos_d;
	logic [BYTE_W-1:0]  sum_q,    sum_d;
	logic [BYTE_W-1:0]  exp_q,    exp_d;
	logic [BYTE_W-1:0]  done_q,   done_d;
	logic [CNT_W-1:0]   cnt_q,    cnt_d;
	logic [BYTE_W-1:0]  fb_q [MAX_RESULTS];
	logic [BYTE_W-1:0]  fb_d [MAX_RESULTS];
	logic [BYTE_W-1:0]  done_inc;

	assign done_inc = done_q + 8'd1;

	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		sum_d     = sum_q;
		exp_d     = exp_q;
		done_d    = done_q;
		cnt_d     = cnt_q;
		fb_d      = fb_q;
		set       = '0;
		if (step) begin
			priority if (rx_byte == sync_byte) begin
				phase_d = PH_HEAD;
				pos_d   = '0;
				sum_d   = '0;
				cnt_d   = '0;
				done_d  = '0;
			end else if (phase_q != PH_HEAD && phase_q != PH_DATA) begin
				phase_d = phase_q;
			end else if (cnt_q >= CNT_W'(OUT_CAPACITY)) begin
				phase_d = PH_IDLE;
				cnt_d   = '0;
			end else if (phase_q == PH_HEAD) begin
				priority if (pos_q >= HDR_LEN) begin
					if (~sum_q == rx_byte) begin
						phase_d = (exp_q == '0) ? PH_IDLE : PH_DATA;
					end else begin
						phase_d = PH_IDLE;
					end
					pos_d = '0;
					sum_d = '0;
				end else if (pos_q == '0 && rx_byte != HDR_CMD) begin
					phase_d = PH_IDLE;
				end else begin
					if (pos_q == HDR_FRAMES) begin
						exp_d = rx_byte;
					end
					if (pos_q == HDR_DST_HI || pos_q == HDR_SRC_LO || pos_q == HDR_FRAMES) begin
						set.res[0].kind  = KIND_HEADER;
						set.res[0].value = rx_byte;
						set.res[0].slot  = cnt_q[SLOT_W-1:0];
						set.count        = COUNT_W'(1);
						cnt_d            = cnt_q + CNT_W'(1);
					end
					pos_d = pos_q + POS_W'(1);
					sum_d = sum_q + rx_byte;
				end
			end else begin
				priority if (pos_q < FRM_DATA_N) begin
					fb_d[pos_q[IDX_W-1:0]] = rx_byte;
					sum_d = sum_q + rx_byte;
					pos_d = pos_q + POS_W'(1);
				end else if (pos_q == FRM_SEPTET) begin
					sum_d = sum_q + rx_byte;
					for (int i = 0; i < MAX_RESULTS; i++) begin
						fb_d[i] = fb_q[i] + {rx_byte[i], 7'b0};
					end
					pos_d = pos_q + POS_W'(1);
				end else begin
					if ({1'b0, ~sum_q[6:0]} == rx_byte) begin
						for (int i = 0; i < MAX_RESULTS; i++) begin
							set.res[i].kind  = KIND_DATA;
							set.res[i].value = fb_q[i];
							set.res[i].slot  = cnt_q[SLOT_W-1:0] + SLOT_W'(i);
						end
						set.count = COUNT_W'(MAX_RESULTS);
						cnt_d     = cnt_q + CNT_W'(MAX_RESULTS);
					end else begin
						set.res[0].kind  = KIND_ERROR;
						set.res[0].value = '0;
						set.res[0].slot  = cnt_q[SLOT_W-1:0];
						set.count        = COUNT_W'(1);
					end
					done_d = done_inc;
					if (done_inc == exp_q) begin
						phase_d = PH_IDLE;
						exp_d   = '0;
					end
					pos_d = '0;
					sum_d = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q   <= '0;
			sum_q   <= '0;
			exp_q   <= '0;
			done_q  <= '0;
			cnt_q   <= '0;
		end else begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			sum_q   <= sum_d;
			exp_q   <= exp_d;
			done_q  <= done_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		fb_q <= fb_d;
	end

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(OUT_CAPACITY + MAX_RESULTS - 1))
		else $error("emitted count past capacity margin");
	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(set.count != '0) |-> (phase_q != PH_IDLE && step))
		else $error("results produced while idle");
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= HDR_LEN)
		else $error("position past header checksum byte");
`endif

endmodule

// ----- rtl/core/vbus_frame_receiver_top.sv -----
// Byte-serial frame receiver for a two-wire heating-controller bus.
// rx:  one received byte per word, accepted on valid && ready.
// res: result words (kind, value, slot, last); last marks the final result
//      that one received byte produced. Bytes that produce nothing give no word.
// cfg: write-only word that sets the sync byte value; ready is always high.
// A byte accepted into the input register is decoded when the result buffer
// can take its results; they are registered into the buffer and offered from it.
// Throughput: one byte per cycle while the results drain freely. A good data
// frame checksum produces four words, so that byte occupies the four-entry
// result buffer until all four words are taken.
// A new byte is taken into the input register while results still wait.
// Stall: when res.ready is low the buffer holds, the input register fills,
// and rx.ready drops until the last buffered result is taken.
// Reset: parser idle, all counters cleared, buffers empty, sync byte 0xAA.
module vbus_frame_receiver_top #(
	parameter int OUT_CAPACITY = 64
) (
	input logic          clk,
	input logic          arst_n,
	vbfr_byte_if.sink    rx,
	vbfr_result_if.source res,
	vbfr_cfg_if.sink     cfg
);
	import vbfr_pkg::*;

	logic [BYTE_W-1:0]  sync_q;
	logic [BYTE_W-1:0]  byte_s1;
	logic               valid_s1;
	result_t            res_q [MAX_RESULTS];
	logic [COUNT_W-1:0] pend_q;
	logic [IDX_W-1:0]   idx_q;
	logic               load;
	logic               out_fire;
	result_set_t        set;

	assign cfg.ready = 1'b1;
	assign out_fire  = res.valid && res.ready;
	assign load      = valid_s1 && (pend_q == '0 || (pend_q == COUNT_W'(1) && res.ready));
	assign rx.ready  = !valid_s1 || load;

	vbfr_parser #(
		.OUT_CAPACITY(OUT_CAPACITY)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (load),
		.rx_byte  (byte_s1),
		.sync_byte(sync_q),
		.set      (set)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q   <= SYNC_RESET;
			valid_s1 <= 1'b0;
			pend_q   <= '0;
			idx_q    <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				sync_q <= cfg.data;
			end
			if (rx.valid && rx.ready) begin
				valid_s1 <= 1'b1;
			end else if (load) begin
				valid_s1 <= 1'b0;
			end
			if (load) begin
				pend_q <= set.count;
				idx_q  <= '0;
			end else if (out_fire) begin
				pend_q <= pend_q - COUNT_W'(1);
				idx_q  <= idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
		if (load) begin
			for (int i = 0; i < MAX_RESULTS; i++) begin
				res_q[i] <= set.res[i];
			end
		end
	end

	assign res.valid = (pend_q != '0);
	assign res.kind  = res_q[idx_q].kind;
	assign res.value = res_q[idx_q].value;
	assign res.slot  = res_q[idx_q].slot;
	assign res.last  = (pend_q == COUNT_W'(1));

`ifndef ASSERT_OFF
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= COUNT_W'(MAX_RESULTS))
		else $error("result buffer count overflow");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (pend_q == '0 || (pend_q == COUNT_W'(1) && out_fire)))
		else $error("result buffer overwritten before drained");
	a_new_set: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && res.last) |=> (!res.valid || idx_q == '0))
		else $error("result set did not restart after last word");
`endif

endmodule

// ----- verif/vbus_frame_receiver_top_tb.sv -----
`timescale 1ns / 100ps

module vbus_frame_receiver_top_tb;
	import vbfr_pkg::*;

	localparam int OUT_CAPACITY   = 64;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int LOUD_LIMIT     = 40;

	typedef enum logic [1:0] {
		RX_IDLE,
		RX_HEAD,
		RX_DATA
	} rx_phase_t;

	typedef enum int {
		FLAW_NONE,
		FLAW_CMD,
		FLAW_HDR_SUM,
		FLAW_FRAME_SUM,
		FLAW_CUT
	} flaw_t;

	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] value;
		logic [SLOT_W-1:0] slot;
		logic              last;
	} word_t;

	logic clk;
	logic arst_n;

	vbfr_byte_if   rx_bus ();
	vbfr_result_if res_bus ();
	vbfr_cfg_if    cfg_bus ();

	vbus_frame_receiver_top #(
		.OUT_CAPACITY(OUT_CAPACITY)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx_bus),
		.res   (res_bus),
		.cfg   (cfg_bus)
	);

	// receiver state as the block should hold it
	logic [BYTE_W-1:0] rcv_sync;
	rx_phase_t         rcv_phase;
	logic [POS_W-1:0]  rcv_pos;
	logic [BYTE_W-1:0] rcv_sum;
	logic [BYTE_W-1:0] rcv_frames_exp;
	logic [BYTE_W-1:0] rcv_frames_done;
	int                rcv_emitted;
	logic [BYTE_W-1:0] rcv_frame [4];

	word_t decoded_q [$];

	bit steady;
	int fail_count;
	int bytes_sent;
	int live_bytes;
	int words_seen;
	int error_markers;
	int capacity_resets;
	int sync_writes;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic decode_byte(input logic [BYTE_W-1:0] b);
		word_t w [MAX_RESULTS];
		int    n;
		n = 0;
		if (b == rcv_sync || rcv_phase != RX_IDLE)
			live_bytes++;
		if (b == rcv_sync) begin
			rcv_phase       = RX_HEAD;
			rcv_pos         = '0;
			rcv_sum         = '0;
			rcv_emitted     = 0;
			rcv_frames_done = '0;
		end else if (rcv_phase == RX_IDLE) begin
			n = 0;
		end else if (rcv_emitted >= OUT_CAPACITY) begin
			rcv_phase   = RX_IDLE;
			rcv_emitted = 0;
			capacity_resets++;
		end else if (rcv_phase == RX_HEAD) begin
			if (rcv_pos >= HDR_LEN) begin
				if ((rcv_sum ^ 8'hFF) == b)
					rcv_phase = (rcv_frames_exp == 0) ? RX_IDLE : RX_DATA;
				else
					rcv_phase = RX_IDLE;
				rcv_pos = '0;
				rcv_sum = '0;
			end else if (rcv_pos == 0 && b != HDR_CMD) begin
				rcv_phase = RX_IDLE;
			end else begin
				if (rcv_pos == HDR_FRAMES)
					rcv_frames_exp = b;
				if (rcv_pos == HDR_DST_HI || rcv_pos == HDR_SRC_LO || rcv_pos == HDR_FRAMES) begin
					w[n].kind  = KIND_HEADER;
					w[n].value = b;
					w[n].slot  = rcv_emitted[SLOT_W-1:0];
					n++;
					rcv_emitted++;
				end
				rcv_pos = rcv_pos + 1'b1;
				rcv_sum = rcv_sum + b;
			end
		end else begin
			if (rcv_pos < FRM_SEPTET) begin
				rcv_frame[rcv_pos[1:0]] = b;
				rcv_sum = rcv_sum + b;
				rcv_pos = rcv_pos + 1'b1;
			end else if (rcv_pos == FRM_SEPTET) begin
				rcv_sum = rcv_sum + b;
				for (int i = 0; i < 4; i++)
					rcv_frame[i] = rcv_frame[i] + (b[i] ? 8'h80 : 8'h00);
				rcv_pos = rcv_pos + 1'b1;
			end else begin
				if (((rcv_sum ^ 8'hFF) & 8'h7F) == b) begin
					for (int i = 0; i < 4; i++) begin
						w[n].kind  = KIND_DATA;
						w[n].value = rcv_frame[i];
						w[n].slot  = rcv_emitted[SLOT_W-1:0];
						n++;
						rcv_emitted++;
					end
				end else begin
					w[n].kind  = KIND_ERROR;
					w[n].value = '0;
					w[n].slot  = rcv_emitted[SLOT_W-1:0];
					n++;
					error_markers++;
				end
				rcv_frames_done = rcv_frames_done + 1'b1;
				if (rcv_frames_done == rcv_frames_exp) begin
					rcv_phase      = RX_IDLE;
					rcv_frames_exp = '0;
				end
				rcv_pos = '0;
				rcv_sum = '0;
			end
		end
		for (int i = 0; i < n; i++) begin
			w[i].last = (i == n - 1);
			decoded_q.push_back(w[i]);
		end
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			rx_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_bus.valid   <= 1'b1;
		rx_bus.rx_byte <= b;
		@(posedge clk);
		while (!rx_bus.ready)
			@(posedge clk);
		decode_byte(b);
		bytes_sent++;
	endtask

	function automatic logic [BYTE_W-1:0] pick_content();
		logic [BYTE_W-1:0] v;
		v = 8'($urandom);
		while (v == rcv_sync)
			v = 8'($urandom);
		return v;
	endfunction

	// pattern: fixed extreme bytes, septet with every bit set
	task automatic send_packet(input int nframes, input flaw_t flaw, input bit pattern);
		logic [BYTE_W-1:0] pkt [$];
		logic [BYTE_W-1:0] ext [4];
		logic [BYTE_W-1:0] v;
		logic [BYTE_W-1:0] sum;
		int                cut;
		ext[0] = 8'h00;
		ext[1] = 8'hFF;
		ext[2] = 8'h80;
		ext[3] = 8'h7F;
		pkt.push_back(rcv_sync);
		if (flaw == FLAW_CMD) begin
			v = pick_content();
			while (v == HDR_CMD)
				v = pick_content();
		end else begin
			v = HDR_CMD;
		end
		pkt.push_back(v);
		sum = v;
		for (int i = 1; i < 7; i++) begin
			v = pattern ? ext[i % 4] : pick_content();
			pkt.push_back(v);
			sum = sum + v;
		end
		v = 8'(nframes);
		pkt.push_back(v);
		sum = sum + v;
		v = sum ^ 8'hFF;
		if (flaw == FLAW_HDR_SUM)
			v = v ^ (8'h01 << $urandom_range(0, 7));
		pkt.push_back(v);
		for (int f = 0; f < nframes; f++) begin
			sum = '0;
			for (int i = 0; i < 5; i++) begin
				if (i == 4)
					v = pattern ? 8'hFF : 8'($urandom);
				else
					v = pattern ? ext[(i + f) % 4] : pick_content();
				pkt.push_back(v);
				sum = sum + v;
			end
			v = (sum ^ 8'hFF) & 8'h7F;
			if (flaw == FLAW_FRAME_SUM && f == nframes - 1)
				v = v ^ (8'h01 << $urandom_range(0, 7));
			pkt.push_back(v);
		end
		if (flaw == FLAW_CUT) begin
			cut = $urandom_range(1, pkt.size() - 1);
			while (pkt.size() > cut)
				void'(pkt.pop_back());
		end
		foreach (pkt[i])
			send_byte(pkt[i]);
	endtask

	task automatic settle();
		rx_bus.valid <= 1'b0;
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_sync(input logic [BYTE_W-1:0] v);
		cfg_bus.valid <= 1'b1;
		cfg_bus.data  <= v;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		cfg_bus.valid <= 1'b0;
		rcv_sync = v;
		sync_writes++;
	endtask

	task automatic test_directed();
		send_byte(8'h55);
		send_byte(rcv_sync);
		send_byte(8'h11);
		// header cut short by a fresh sync
		send_byte(rcv_sync);
		send_byte(HDR_CMD);
		send_byte(8'h00);
		send_packet(2, FLAW_FRAME_SUM, 1'b1);
	endtask

	// sixteen good frames pass the output capacity; the next byte forces idle
	task automatic test_capacity();
		send_packet(17, FLAW_NONE, 1'b0);
		send_byte(8'($urandom));
	endtask

	task automatic test_random_frames(input int target);
		int stop_at;
		int pick;
		stop_at = live_bytes + target;
		while (live_bytes < stop_at) begin
			steady = ($urandom_range(0, 7) == 0);
			pick   = $urandom_range(0, 9);
			if (pick <= 5)
				send_packet($urandom_range(0, 3), FLAW_NONE, 1'b0);
			else if (pick == 6)
				send_packet($urandom_range(1, 3), FLAW_FRAME_SUM, 1'b0);
			else if (pick == 7)
				send_packet($urandom_range(0, 3),
					$urandom_range(0, 1) ? FLAW_CMD : FLAW_HDR_SUM, 1'b0);
			else if (pick == 8)
				send_packet($urandom_range(1, 3), FLAW_CUT, 1'b0);
			else
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
		end
		steady = 1'b0;
	endtask

	task automatic test_sync_settings();
		logic [BYTE_W-1:0] v;
		settle();
		write_sync(8'h00);
		test_random_frames(35);
		settle();
		write_sync(8'hFF);
		test_random_frames(35);
		v = 8'($urandom_range(1, 254));
		while (v == HDR_CMD)
			v = 8'($urandom_range(1, 254));
		settle();
		write_sync(v);
		test_random_frames(35);
	endtask

	initial begin : word_monitor
		int    stall;
		word_t w;
		bit    loud;
		stall = 0;
		forever begin
			@(posedge clk);
			if (res_bus.valid && res_bus.ready) begin
				words_seen++;
				loud = (fail_count < LOUD_LIMIT);
				if (decoded_q.size() == 0) begin
					fail_count++;
					if (loud)
						$display("%0t: unexpected word, expected none, actual kind %0d value %0h slot %0d",
							$time, res_bus.kind, res_bus.value, res_bus.slot);
				end else begin
					w = decoded_q.pop_front();
					if (res_bus.kind !== w.kind) begin
						fail_count++;
						if (loud)
							$display("%0t: kind expected %0d actual %0d",
								$time, w.kind, res_bus.kind);
					end
					if (res_bus.value !== w.value) begin
						fail_count++;
						if (loud)
							$display("%0t: value expected %0h actual %0h",
								$time, w.value, res_bus.value);
					end
					if (res_bus.slot !== w.slot) begin
						fail_count++;
						if (loud)
							$display("%0t: slot expected %0d actual %0d",
								$time, w.slot, res_bus.slot);
					end
					if (res_bus.last !== w.last) begin
						fail_count++;
						if (loud)
							$display("%0t: last expected %0b actual %0b",
								$time, w.last, res_bus.last);
					end
				end
				stall = steady ? 0 : $urandom_range(0, 4);
				if (stall > 0)
					res_bus.ready <= 1'b0;
			end else if (!res_bus.ready) begin
				stall--;
				if (stall <= 0)
					res_bus.ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((rx_bus.valid && rx_bus.ready) || (res_bus.valid && res_bus.ready) ||
				(cfg_bus.valid && cfg_bus.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("vbus_frame_receiver_top test failed");
		$finish;
	end

	initial begin
		rx_bus.valid    <= 1'b0;
		rx_bus.rx_byte  <= '0;
		res_bus.ready   <= 1'b1;
		cfg_bus.valid   <= 1'b0;
		cfg_bus.data    <= '0;
		arst_n          <= 1'b0;
		rcv_sync        = SYNC_RESET;
		rcv_phase       = RX_IDLE;
		rcv_pos         = '0;
		rcv_sum         = '0;
		rcv_frames_exp  = '0;
		rcv_frames_done = '0;
		rcv_emitted     = 0;
		steady          = 1'b0;
		fail_count      = 0;
		bytes_sent      = 0;
		live_bytes      = 0;
		words_seen      = 0;
		error_markers   = 0;
		capacity_resets = 0;
		sync_writes     = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_capacity();
		test_random_frames(35);
		test_sync_settings();
		settle();

		$display("Sent %0d bytes (%0d decoded), checked %0d words over %0d sync values",
			bytes_sent, live_bytes, words_seen, sync_writes + 1);
		$display("Frame checksum errors %0d, capacity resets %0d", error_markers,
			capacity_resets);
		if (fail_count == 0)
			$display("vbus_frame_receiver_top test passed");
		else
			$display("vbus_frame_receiver_top test failed");
		$finish;
	end

endmodule

// ----- vbus_frame_receiver_top.f -----
rtl/core/vbfr_pkg.sv
rtl/core/vbfr_if.sv
rtl/core/vbfr_parser.sv
rtl/core/vbus_frame_receiver_top.sv
verif/vbus_frame_receiver_top_tb.sv
